FILE: design/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256 package
// shared request/response types, round constants and round functions
// ----------------------------------------------------------------------------
package sha256_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   // one staged request: byte, whether it is a byte, whether it ends the message
   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_message;
   } cmd_type;

   localparam logic [31:0] INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam int unsigned LEN_POS = 56;

   function automatic logic [31:0] round_k(input logic [5:0] idx);
      logic [31:0] k;
      case (idx)
         6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
         6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
         6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
         6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
         6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
      return (v >> n) | (v << (32 - n));
   endfunction

   function automatic logic [31:0] sig0(input logic [31:0] x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] sig1(input logic [31:0] x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] big0(input logic [31:0] x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big1(input logic [31:0] x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

endpackage

FILE: design/sha256_cmd_fifo.sv
// ----------------------------------------------------------------------------
// sha256 request queue
// short queue between the front classifier and the block engine
// ----------------------------------------------------------------------------
module sha256_cmd_fifo
   import sha256_pkg::*;
#(
   parameter int unsigned DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  cmd_type wr_data,
   output logic    full,
   input  logic    rd_en,
   output cmd_type rd_data,
   output logic    empty
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   cmd_type        mem_ff [DEPTH];
   logic [AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [AW:0]    count_ff, count_in;

   assign full    = (count_ff == (AW+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (!wr_en && rd_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: design/sha256_engine.sv
// ----------------------------------------------------------------------------
// sha256 block engine
// buffers bytes, pads, runs one round per cycle, streams the digest
// ----------------------------------------------------------------------------
module sha256_engine
   import sha256_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_empty,
   input  cmd_type cmd_data,
   output logic    cmd_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE, S_PAD, S_ZERO, S_LEN, S_ROUND, S_ADD, S_OUT
   } state_type;

   state_type    state_ff;
   logic [31:0]  h_ff [8];
   logic [31:0]  s_ff [8];
   logic [31:0]  w_ff [16];
   logic [5:0]   fill_ff;
   logic [63:0]  total_ff;
   logic [5:0]   rnd_ff;
   logic         final_ff;
   logic         second_ff;
   logic         pad_due_ff;
   logic [2:0]   out_idx_ff;
   logic [2:0]   len_idx_ff;

   logic [31:0]  w_cur, w_new, t1, t2;
   logic [63:0]  bits;
   logic [7:0]   len_byte;
   logic [31:0]  h_out;

   // round schedule: w_ff[0] is the word for this round
   assign w_cur = w_ff[0];
   assign w_new = w_ff[0] + sig0(w_ff[1]) + w_ff[9] + sig1(w_ff[14]);
   assign t1    = s_ff[7] + big1(s_ff[4]) + ((s_ff[4] & s_ff[5]) ^ (~s_ff[4] & s_ff[6]))
                  + round_k(rnd_ff) + w_cur;
   assign t2    = big0(s_ff[0]) + ((s_ff[0] & s_ff[1]) ^ (s_ff[0] & s_ff[2])
                  ^ (s_ff[1] & s_ff[2]));
   assign bits     = {total_ff[60:0], 3'b000};
   assign len_byte = bits[8*(7 - len_idx_ff) +: 8];
   assign h_out    = h_ff[out_idx_ff];

   assign cmd_pop   = (state_ff == S_IDLE) && !cmd_empty;
   assign rsp_empty = (state_ff != S_OUT);
   assign rsp_data  = '{digest_word: h_out, word_index: out_idx_ff,
                        last_word: (out_idx_ff == 3'd7)};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         fill_ff    <= '0;
         total_ff   <= '0;
         final_ff   <= 1'b0;
         second_ff  <= 1'b0;
         pad_due_ff <= 1'b0;
         out_idx_ff <= '0;
         len_idx_ff <= '0;
         rnd_ff     <= '0;
         for (int i = 0; i < 8; i++) h_ff[i] <= INIT_H[i];
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (!cmd_empty) begin
                  if (cmd_data.has_byte) begin
                     w_ff[fill_ff[5:2]][8*(3 - fill_ff[1:0]) +: 8] <= cmd_data.data_byte;
                     total_ff <= total_ff + 64'd1;
                     fill_ff  <= fill_ff + 6'd1;
                     final_ff <= cmd_data.end_of_message;
                     if (fill_ff == 6'd63) begin
                        // padding still owed after this block when the request ends it
                        pad_due_ff <= cmd_data.end_of_message;
                        rnd_ff <= '0;
                        for (int i = 0; i < 8; i++) s_ff[i] <= h_ff[i];
                        state_ff <= S_ROUND;
                     end else if (cmd_data.end_of_message) begin
                        state_ff <= S_PAD;
                     end
                  end else if (cmd_data.end_of_message) begin
                     final_ff <= 1'b1;
                     state_ff <= S_PAD;
                  end
               end
            end
            S_PAD: begin
               w_ff[fill_ff[5:2]][8*(3 - fill_ff[1:0]) +: 8] <= PAD_BYTE;
               fill_ff  <= fill_ff + 6'd1;
               second_ff <= (fill_ff >= 6'(LEN_POS));
               state_ff <= S_ZERO;
            end
            S_ZERO: begin
               // zero to length slot, or to block end when no room
               if (fill_ff == 6'(LEN_POS) && !second_ff) begin
                  len_idx_ff <= '0;
                  state_ff   <= S_LEN;
               end else if (fill_ff == 6'd0) begin
                  rnd_ff <= '0;
                  for (int i = 0; i < 8; i++) s_ff[i] <= h_ff[i];
                  state_ff <= S_ROUND;
               end else begin
                  w_ff[fill_ff[5:2]][8*(3 - fill_ff[1:0]) +: 8] <= 8'h00;
                  fill_ff <= fill_ff + 6'd1;
                  if (fill_ff > 6'(LEN_POS)) second_ff <= 1'b1;
                  if (fill_ff == 6'd63) second_ff <= 1'b1;
               end
            end
            S_LEN: begin
               w_ff[fill_ff[5:2]][8*(3 - fill_ff[1:0]) +: 8] <= len_byte;
               fill_ff    <= fill_ff + 6'd1;
               len_idx_ff <= len_idx_ff + 3'd1;
               if (len_idx_ff == 3'd7) begin
                  second_ff <= 1'b0;
                  rnd_ff    <= '0;
                  for (int i = 0; i < 8; i++) s_ff[i] <= h_ff[i];
                  state_ff  <= S_ROUND;
               end
            end
            S_ROUND: begin
               s_ff[7] <= s_ff[6];
               s_ff[6] <= s_ff[5];
               s_ff[5] <= s_ff[4];
               s_ff[4] <= s_ff[3] + t1;
               s_ff[3] <= s_ff[2];
               s_ff[2] <= s_ff[1];
               s_ff[1] <= s_ff[0];
               s_ff[0] <= t1 + t2;
               for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
               w_ff[15] <= w_new;
               rnd_ff <= rnd_ff + 6'd1;
               if (rnd_ff == 6'd63) state_ff <= S_ADD;
            end
            S_ADD: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + s_ff[i];
               out_idx_ff <= '0;
               if (pad_due_ff) begin
                  // block filled by the end request; pad a fresh block
                  pad_due_ff <= 1'b0;
                  state_ff   <= S_PAD;
               end else if (!final_ff) begin
                  state_ff <= S_IDLE;
               end else if (second_ff) begin
                  // padding spilled; next block carries zeros and length
                  second_ff <= 1'b0;
                  state_ff  <= S_ZERO;
                  fill_ff   <= 6'd1;
                  w_ff[0]   <= '0;
               end else begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (rsp_pop) begin
                  out_idx_ff <= out_idx_ff + 3'd1;
                  if (out_idx_ff == 3'd7) begin
                     for (int i = 0; i < 8; i++) h_ff[i] <= INIT_H[i];
                     fill_ff  <= '0;
                     total_ff <= '0;
                     final_ff <= 1'b0;
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

FILE: design/sha256_byte_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// sha256 byte stream hasher core
// a byte that fills a block holds the engine for 64 rounds of compression
// other bytes pass through the request queue and the engine idle state
// an end request adds padding plus one or two block compressions
// digest leaves as eight words, one per cycle while pop is high
// reset: synchronous, restores initial hash, empties queue and counts
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_core
   import sha256_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   input  logic    rsp_pop,
   output rsp_type rsp_data,
   output logic    rsp_empty
);

   cmd_type q_in, q_out;
   logic    q_empty, q_pop, keep;

   // front: classify, drop requests that carry nothing
   assign keep = req_data.has_byte || req_data.end_of_message;
   assign q_in = '{data_byte: req_data.data_byte, has_byte: req_data.has_byte,
                   end_of_message: req_data.end_of_message};

   sha256_cmd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_push && !req_full && keep),
      .wr_data (q_in),
      .full    (req_full),
      .rd_en   (q_pop),
      .rd_data (q_out),
      .empty   (q_empty)
   );

   sha256_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (q_empty),
      .cmd_data  (q_out),
      .cmd_pop   (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: design/sha256_checker.sv
// ----------------------------------------------------------------------------
// sha256 port checker
// port-level checks on the response stream
// ----------------------------------------------------------------------------
module sha256_checker
   import sha256_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_pop,
   input logic    rsp_empty,
   input rsp_type rsp_data
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("response changed while stalled");

   a_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.last_word == (rsp_data.word_index == 3'd7)))
      else $error("last flag mismatch");

   a_next: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_data.last_word) |=>
      (!rsp_empty && rsp_data.word_index == $past(rsp_data.word_index) + 3'd1))
      else $error("digest words not contiguous");

   a_first: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && rsp_data.last_word) |=> rsp_empty)
      else $error("response after last word");

endmodule

bind sha256_byte_stream_hasher_core sha256_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_pop   (rsp_pop),
   .rsp_empty (rsp_empty),
   .rsp_data  (rsp_data)
);

FILE: tb/tb_sha256_byte_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// sha256 byte stream hasher core testbench
// streams messages one byte per request, predicts each digest with an
// independent sha-256 model and checks every digest word in order
// ----------------------------------------------------------------------------
module tb_sha256_byte_stream_hasher_core;
   import sha256_pkg::*;

   localparam int unsigned TAIL_CYCLES = 400;

   logic    clock;
   logic    reset;
   logic    req_push;
   req_type req_data;
   logic    req_full;
   logic    rsp_pop;
   rsp_type rsp_data;
   logic    rsp_empty;

   sha256_byte_stream_hasher_core u_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_data(req_data), .req_full(req_full),
      .rsp_pop(rsp_pop), .rsp_data(rsp_data), .rsp_empty(rsp_empty)
   );

   // predictor state
   logic [31:0] hash_state [8];
   logic [7:0]  msg_block [64];
   int unsigned block_fill;
   logic [63:0] msg_length;
   rsp_type     digest_queue [$];

   int unsigned mismatch_count;
   int unsigned send_idle_pct;
   int unsigned pop_stall_pct;

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] ror32(logic [31:0] v, int n);
      return {v, v} >> n;
   endfunction

   task automatic hash_block();
      logic [31:0] sched [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int i = 0; i < 16; i++)
         sched[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      for (int i = 16; i < 64; i++)
         sched[i] = sched[i-16] + sched[i-7]
            + (ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18) ^ (sched[i-15] >> 3))
            + (ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19) ^ (sched[i-2] >> 10));
      a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
      e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
      for (int i = 0; i < 64; i++) begin
         t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
            + ROUND_CONST[i] + sched[i];
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
      end
      hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
      hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
   endtask

   task automatic restart_message();
      hash_state = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                     32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      block_fill = 0;
      msg_length = '0;
   endtask

   task automatic predict_digest(req_type r);
      logic [63:0] bit_len;
      rsp_type     w;
      if (r.has_byte) begin
         msg_block[block_fill] = r.data_byte;
         block_fill++;
         msg_length++;
         if (block_fill == 64) begin
            hash_block();
            block_fill = 0;
         end
      end
      if (!r.end_of_message) return;
      bit_len = msg_length << 3;
      msg_block[block_fill] = PAD_BYTE;
      block_fill++;
      if (block_fill > LEN_POS) begin
         for (int i = block_fill; i < 64; i++) msg_block[i] = 8'h00;
         hash_block();
         block_fill = 0;
      end
      for (int i = block_fill; i < 56; i++) msg_block[i] = 8'h00;
      for (int i = 0; i < 8; i++) msg_block[63-i] = bit_len[8*i +: 8];
      hash_block();
      for (int i = 0; i < 8; i++) begin
         w.digest_word = hash_state[i];
         w.word_index  = 3'(i);
         w.last_word   = (i == 7);
         digest_queue.push_back(w);
      end
      restart_message();
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // sender: one request per call, random idle before it
   task automatic send_request(logic [7:0] data, logic has, logic eom);
      req_type r;
      r.data_byte = data; r.has_byte = has; r.end_of_message = eom;
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_full);
      predict_digest(r);
      @(negedge clock);
   endtask

   task automatic send_message(int unsigned len, logic eom_has_byte);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(15) == 0) send_request(8'($urandom), 1'b0, 1'b0);
         send_request(8'($urandom), 1'b1, 1'b0);
      end
      send_request(8'($urandom), eom_has_byte, 1'b1);
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (digest_queue.size() != 0) @(negedge clock);
   endtask

   // receiver and checker
   always @(negedge clock) begin
      if (reset) rsp_pop <= 1'b0;
      else rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
   end

   always @(posedge clock) begin
      rsp_type exp_w;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (digest_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected digest word %h idx %0d", rsp_data.digest_word,
                        rsp_data.word_index);
         end else begin
            exp_w = digest_queue.pop_front();
            if (rsp_data !== exp_w) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("digest mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
                           exp_w.digest_word, exp_w.word_index, exp_w.last_word,
                           rsp_data.digest_word, rsp_data.word_index, rsp_data.last_word);
            end
         end
      end
   end

   task automatic test_directed();
      send_request(8'h00, 1'b0, 1'b1);             // empty message
      send_request(8'h61, 1'b1, 1'b0);             // "abc"
      send_request(8'h62, 1'b1, 1'b0);
      send_request(8'h63, 1'b1, 1'b1);
      send_request(8'h00, 1'b0, 1'b0);             // no byte, no end
      send_request(8'hff, 1'b1, 1'b0);
      send_request(8'h00, 1'b1, 1'b0);
      send_request(8'haa, 1'b0, 1'b0);
      send_request(8'h55, 1'b1, 1'b1);
      send_request(8'hff, 1'b1, 1'b1);             // single byte message
   endtask

   task automatic test_block_edges();
      send_message(63, 1'b0);                      // pad byte closes the block
      send_message(63, 1'b1);                      // block fills on the end item
   endtask

   task automatic test_random_messages(int unsigned n);
      for (int i = 0; i < n; i++)
         send_message($urandom_range(0, 6), 1'($urandom));
   endtask

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      rsp_pop = 1'b0;
      mismatch_count = 0;
      send_idle_pct = 0;
      pop_stall_pct = 0;
      restart_message();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_block_edges();
      wait_drained();
      send_idle_pct = 51;
      test_random_messages(3);
      send_idle_pct = 0;
      pop_stall_pct = 51;
      test_random_messages(3);
      send_idle_pct = 24;
      pop_stall_pct = 24;
      test_random_messages(3);
      send_idle_pct = 0;
      pop_stall_pct = 0;
      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && digest_queue.size() == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   initial begin
      #5000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: sim.f
design/sha256_pkg.sv
design/sha256_cmd_fifo.sv
design/sha256_engine.sv
design/sha256_byte_stream_hasher_core.sv
design/sha256_checker.sv
tb/tb_sha256_byte_stream_hasher_core.sv
